// ===== design/four_level_page_table_walker_defines.svh =====
// Assertion macros shared by the page walker checker.
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FPTW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define FPTW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/fptw_pkg.sv =====
// Types, constants and codes of the four-level page walker.
package fptw_pkg;

  localparam int unsigned PA_MAX_W      = 52;
  localparam int unsigned VADDR_W       = 48;
  localparam int unsigned ENTRY_W       = 64;
  localparam int unsigned PNONE_W       = 6;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned CFG_DATA_W    = PA_MAX_W;
  localparam int unsigned PADDR_BITS_DEF = 52;

  localparam logic [PNONE_W-1:0] PNONE_RESET = 6'd9;

  // Entry bit positions
  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_HUGE    = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROT_NONE_BIT   = 1'd1;

  typedef enum logic {
    REQ_TRANSLATE = 1'b0,
    REQ_RESPONSE  = 1'b1
  } req_type_e;

  // Waiting level: which table's entry is expected next
  typedef enum logic [2:0] {
    LVL_IDLE = 3'd0,
    LVL_1    = 3'd1,
    LVL_2    = 3'd2,
    LVL_3    = 3'd3,
    LVL_4    = 3'd4
  } walk_level_e;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_DONE  = 2'd1,
    KIND_FAULT = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    PAGE_4K = 2'd0,
    PAGE_2M = 2'd1,
    PAGE_1G = 2'd2
  } frame_size_e;

  typedef struct packed {
    logic                emit;
    result_kind_e        kind;
    logic [PA_MAX_W-1:0] read_addr;
    logic [PA_MAX_W-1:0] phys_addr;
    frame_size_e         frame_size;
    logic [1:0]          fault_level;
    walk_level_e         level_nxt;
    logic                latch_va;
  } step_res_t;

endpackage

// ===== design/fptw_step.sv =====
// One walk step: decodes a request or a table entry against the walk state.
module fptw_step import fptw_pkg::*; (
  input  logic                   req_type_i,
  input  logic [VADDR_W-1:0]     virt_addr_i,
  input  logic [ENTRY_W-1:0]     entry_data_i,
  input  walk_level_e            level_i,
  input  logic [VADDR_W-1:0]     saved_vaddr_i,
  input  logic [PA_MAX_W-1:0]    root_table_addr_i,
  input  logic [PNONE_W-1:0]     prot_none_bit_i,
  output step_res_t              res_o
);

  logic walking;
  logic present;
  logic huge;
  logic pnone;

  assign walking = level_i inside {LVL_1, LVL_2, LVL_3, LVL_4};
  assign present = entry_data_i[BIT_PRESENT];
  assign huge    = entry_data_i[BIT_HUGE];
  assign pnone   = entry_data_i[prot_none_bit_i];

  always_comb begin
    res_o             = '0;
    res_o.kind        = KIND_READ;
    res_o.frame_size  = PAGE_4K;
    res_o.level_nxt   = level_i;
    if (req_type_i == REQ_TRANSLATE) begin
      // Requests during a walk are dropped
      if (!walking) begin
        res_o.emit      = 1'b1;
        res_o.latch_va  = 1'b1;
        res_o.level_nxt = LVL_4;
        res_o.read_addr = {root_table_addr_i[PA_MAX_W-1:12], virt_addr_i[47:39], 3'b000};
      end
    end else if (walking) begin
      res_o.emit = 1'b1;
      case (level_i)
        LVL_1: begin
          res_o.level_nxt = LVL_IDLE;
          if (!present && !pnone) begin
            res_o.kind = KIND_FAULT;
          end else begin
            res_o.kind      = KIND_DONE;
            res_o.phys_addr = {entry_data_i[PA_MAX_W-1:12], saved_vaddr_i[11:0]};
          end
        end
        LVL_2: begin
          if (!present) begin
            res_o.level_nxt   = LVL_IDLE;
            res_o.kind        = KIND_FAULT;
            res_o.fault_level = 2'd1;
          end else if (huge) begin
            res_o.level_nxt  = LVL_IDLE;
            res_o.kind       = KIND_DONE;
            res_o.frame_size = PAGE_2M;
            res_o.phys_addr  = {entry_data_i[PA_MAX_W-1:21], saved_vaddr_i[20:0]};
          end else begin
            res_o.level_nxt = LVL_1;
            res_o.read_addr = {entry_data_i[PA_MAX_W-1:12], saved_vaddr_i[20:12], 3'b000};
          end
        end
        LVL_3: begin
          if (!present) begin
            res_o.level_nxt   = LVL_IDLE;
            res_o.kind        = KIND_FAULT;
            res_o.fault_level = 2'd2;
          end else if (huge) begin
            res_o.level_nxt  = LVL_IDLE;
            res_o.kind       = KIND_DONE;
            res_o.frame_size = PAGE_1G;
            res_o.phys_addr  = {entry_data_i[PA_MAX_W-1:30], saved_vaddr_i[29:0]};
          end else begin
            res_o.level_nxt = LVL_2;
            res_o.read_addr = {entry_data_i[PA_MAX_W-1:12], saved_vaddr_i[29:21], 3'b000};
          end
        end
        LVL_4: begin
          // Huge bit means nothing at the top level
          if (!present) begin
            res_o.level_nxt   = LVL_IDLE;
            res_o.kind        = KIND_FAULT;
            res_o.fault_level = 2'd3;
          end else begin
            res_o.level_nxt = LVL_3;
            res_o.read_addr = {entry_data_i[PA_MAX_W-1:12], saved_vaddr_i[38:30], 3'b000};
          end
        end
        default: begin
          res_o.emit      = 1'b0;
          res_o.level_nxt = LVL_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/four_level_page_table_walker.sv =====
// Four-level page walker: one word in, at most one result word out.
//
// Input channel (in_valid_i/in_ready_o) carries translate requests and
// table-entry responses, told apart by req_type_i. A translate request
// returns a read of the top-level entry; each response returns the next
// read, a translation (phys_addr_o, frame_size_o) or a fault (fault_level_o).
// A request during a walk, or a response while idle, gives no result.
// Output channel (out_valid_o/out_ready_i) carries the result words.
//
// A word accepted into the input register passes through the step logic into
// the output register, which drives out_valid_o. Throughput: one word per
// cycle while the receiver does not stall; the input register feeds the step
// logic, which writes the output register and the walk state in the same cycle.
// While the receiver stalls, the output word holds and the input register
// keeps one more word; in_ready_o drops once both are full.
// Reset empties both registers, ends any walk, sets root_table_addr to 0 and
// prot_none_bit to 9. Configuration is written through cfg_we_i with no wait;
// write it only while no walk is in progress (the block does not enforce it).
module four_level_page_table_walker import fptw_pkg::*; #(
  parameter int unsigned PADDR_BITS = PADDR_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  req_type_i,
  input  logic [VADDR_W-1:0]    virt_addr_i,
  input  logic [ENTRY_W-1:0]    entry_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [1:0]            result_kind_o,
  output logic [PADDR_BITS-1:0] read_addr_o,
  output logic [PADDR_BITS-1:0] phys_addr_o,
  output logic [1:0]            frame_size_o,
  output logic [1:0]            fault_level_o
);

  logic [PA_MAX_W-1:0]   root_q;
  logic [PNONE_W-1:0]    pnone_q;
  walk_level_e           level_q, level_d;
  logic [VADDR_W-1:0]    svaddr_q, svaddr_d;

  logic                  inv_q;
  logic                  req_q;
  logic [VADDR_W-1:0]    va_q;
  logic [ENTRY_W-1:0]    ent_q;

  logic                  outv_q, outv_d;
  logic [1:0]            kind_q;
  logic [PADDR_BITS-1:0] raddr_q;
  logic [PADDR_BITS-1:0] paddr_q;
  logic [1:0]            size_q;
  logic [1:0]            flvl_q;

  logic                  adv;
  logic                  step_fire;
  step_res_t             res;

  assign adv        = !outv_q || out_ready_i;
  assign in_ready_o = !inv_q || adv;
  assign step_fire  = inv_q && adv;

  fptw_step u_step (
    .req_type_i        (req_q),
    .virt_addr_i       (va_q),
    .entry_data_i      (ent_q),
    .level_i           (level_q),
    .saved_vaddr_i     (svaddr_q),
    .root_table_addr_i (root_q),
    .prot_none_bit_i   (pnone_q),
    .res_o             (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_q  <= '0;
      pnone_q <= PNONE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ROOT_TABLE_ADDR: root_q  <= cfg_wdata_i[PA_MAX_W-1:0];
        CFG_PROT_NONE_BIT:   pnone_q <= cfg_wdata_i[PNONE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    level_d  = level_q;
    svaddr_d = svaddr_q;
    outv_d   = outv_q;
    if (adv) begin
      outv_d = step_fire && res.emit;
    end
    if (step_fire) begin
      level_d = res.level_nxt;
      if (res.latch_va) begin
        svaddr_d = va_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q  <= LVL_IDLE;
      svaddr_q <= '0;
      inv_q    <= 1'b0;
      outv_q   <= 1'b0;
    end else begin
      level_q  <= level_d;
      svaddr_q <= svaddr_d;
      outv_q   <= outv_d;
      if (in_ready_o) begin
        inv_q <= in_valid_i;
      end
    end
  end

  // Input word register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q <= req_type_i;
      va_q  <= virt_addr_i;
      ent_q <= entry_data_i;
    end
  end

  // Result word register; holds while the receiver stalls
  always_ff @(posedge clk_i) begin
    if (step_fire && res.emit) begin
      kind_q  <= res.kind;
      raddr_q <= res.read_addr[PADDR_BITS-1:0];
      paddr_q <= res.phys_addr[PADDR_BITS-1:0];
      size_q  <= res.frame_size;
      flvl_q  <= res.fault_level;
    end
  end

  assign out_valid_o   = outv_q;
  assign result_kind_o = kind_q;
  assign read_addr_o   = raddr_q;
  assign phys_addr_o   = paddr_q;
  assign frame_size_o  = size_q;
  assign fault_level_o = flvl_q;

endmodule

// ===== design/fptw_checker.sv =====
// Port-level checker for the page walker, bound to the top level.
`include "four_level_page_table_walker_defines.svh"

module fptw_checker import fptw_pkg::*; #(
  parameter int unsigned PADDR_BITS = PADDR_BITS_DEF
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [1:0]            result_kind_o,
  input logic [PADDR_BITS-1:0] read_addr_o,
  input logic [PADDR_BITS-1:0] phys_addr_o,
  input logic [1:0]            frame_size_o,
  input logic [1:0]            fault_level_o
);

  `FPTW_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(result_kind_o) && $stable(read_addr_o) && $stable(phys_addr_o), "result word changed while stalled")

  `FPTW_ASSERT_NOW(a_kind_legal, out_valid_o, result_kind_o == KIND_READ || result_kind_o == KIND_DONE || result_kind_o == KIND_FAULT, "illegal result kind")

  `FPTW_ASSERT_NOW(a_read_aligned, out_valid_o && result_kind_o == KIND_READ, read_addr_o[2:0] == 3'd0 && phys_addr_o == '0 && fault_level_o == 2'd0, "read word not an aligned entry address")

  `FPTW_ASSERT_NOW(a_done_only_size, out_valid_o && result_kind_o != KIND_DONE, phys_addr_o == '0 && frame_size_o == PAGE_4K, "translation fields set on a non-translation word")

endmodule

bind four_level_page_table_walker fptw_checker #(.PADDR_BITS(PADDR_BITS)) u_fptw_checker (.*);

// ===== test/tb_four_level_page_table_walker.sv =====
// Self-checking testbench for the four-level page table walker.
`timescale 1ns / 1ps

module tb_four_level_page_table_walker;
  import fptw_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int IDLE_PCT        = 37;
  localparam int MAX_PRINTS      = 60;

  typedef struct packed {
    result_kind_e          kind;
    logic [PA_MAX_W-1:0]   read_addr;
    logic [PA_MAX_W-1:0]   phys_addr;
    frame_size_e           frame_size;
    logic [1:0]            fault_level;
  } walk_out_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  req_type_i;
  logic [VADDR_W-1:0]    virt_addr_i;
  logic [ENTRY_W-1:0]    entry_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [1:0]            result_kind_o;
  logic [PA_MAX_W-1:0]   read_addr_o;
  logic [PA_MAX_W-1:0]   phys_addr_o;
  logic [1:0]            frame_size_o;
  logic [1:0]            fault_level_o;

  // Walker state mirrored by the predictor
  walk_level_e         tb_level   = LVL_IDLE;
  logic [VADDR_W-1:0]  tb_vaddr   = '0;
  logic [PA_MAX_W-1:0] root_q     = '0;
  logic [PNONE_W-1:0]  pnone_pos  = PNONE_RESET;

  walk_out_t pending_outcomes[$];

  int  err_count      = 0;
  int  cycle_count    = 0;
  int  n_result_words = 0;
  int  n_ignored      = 0;
  int  n_checked      = 0;
  int  n_done         = 0;
  int  n_huge         = 0;
  int  n_fault        = 0;
  int  n_walks        = 0;
  int  n_settings     = 0;
  int  hold_off       = 0;
  bit  in_gaps        = 1'b1;
  bit  out_stalls     = 1'b1;

  four_level_page_table_walker u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (req_type_i),
    .virt_addr_i   (virt_addr_i),
    .entry_data_i  (entry_data_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .result_kind_o (result_kind_o),
    .read_addr_o   (read_addr_o),
    .phys_addr_o   (phys_addr_o),
    .frame_size_o  (frame_size_o),
    .fault_level_o (fault_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_outcomes.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [VADDR_W-1:0] rand_va();
    logic [63:0] w;
    w = rand64();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return w[VADDR_W-1:0];
    endcase
  endfunction

  function automatic logic [8:0] tbl_index(input logic [VADDR_W-1:0] va,
                                           input walk_level_e lvl);
    case (lvl)
      LVL_4: return va[47:39];
      LVL_3: return va[38:30];
      LVL_2: return va[29:21];
      default: return va[20:12];
    endcase
  endfunction

  // Advance the mirrored walker by one input word; return 1 if a word comes out
  function automatic bit walk_step(input req_type_e req, input logic [VADDR_W-1:0] va,
                                   input logic [ENTRY_W-1:0] ent, output walk_out_t res);
    logic [PA_MAX_W-1:0] base;
    logic [2:0]          lower;
    res = '0;
    if (req == REQ_TRANSLATE) begin
      if (tb_level != LVL_IDLE) return 1'b0;
      tb_vaddr      = va;
      tb_level      = LVL_4;
      res.kind      = KIND_READ;
      res.read_addr = {root_q[51:12], 12'h000} + {40'd0, tbl_index(va, LVL_4), 3'd0};
      return 1'b1;
    end
    if (tb_level == LVL_IDLE) return 1'b0;
    base  = {ent[51:12], 12'h000};
    lower = tb_level - 3'd1;
    if (tb_level == LVL_1) begin
      tb_level = LVL_IDLE;
      if (!ent[BIT_PRESENT] && !ent[pnone_pos]) begin
        res.kind = KIND_FAULT;
      end else begin
        res.kind       = KIND_DONE;
        res.phys_addr  = {base[51:12], tb_vaddr[11:0]};
        res.frame_size = PAGE_4K;
      end
    end else if (!ent[BIT_PRESENT]) begin
      tb_level        = LVL_IDLE;
      res.kind        = KIND_FAULT;
      res.fault_level = lower[1:0];
    end else if (tb_level == LVL_3 && ent[BIT_HUGE]) begin
      tb_level       = LVL_IDLE;
      res.kind       = KIND_DONE;
      res.phys_addr  = {base[51:30], tb_vaddr[29:0]};
      res.frame_size = PAGE_1G;
    end else if (tb_level == LVL_2 && ent[BIT_HUGE]) begin
      tb_level       = LVL_IDLE;
      res.kind       = KIND_DONE;
      res.phys_addr  = {base[51:21], tb_vaddr[20:0]};
      res.frame_size = PAGE_2M;
    end else begin
      tb_level      = walk_level_e'(lower);
      res.kind      = KIND_READ;
      res.read_addr = base + {40'd0, tbl_index(tb_vaddr, tb_level), 3'd0};
    end
    return 1'b1;
  endfunction

  // Entered and left at a falling edge; valid stays high after acceptance
  task automatic send_word(input req_type_e req, input logic [VADDR_W-1:0] va,
                           input logic [ENTRY_W-1:0] ent);
    walk_out_t res;
    while (in_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    virt_addr_i  <= va;
    entry_data_i <= ent;
    do @(posedge clk_i); while (!in_ready_o);
    if (walk_step(req, va, ent, res)) begin
      pending_outcomes.push_back(res);
      n_result_words++;
    end else begin
      n_ignored++;
    end
    @(negedge clk_i);
  endtask

  task automatic send_translate(input logic [VADDR_W-1:0] va);
    send_word(REQ_TRANSLATE, va, rand64());
  endtask

  task automatic send_entry(input logic [ENTRY_W-1:0] ent);
    send_word(REQ_RESPONSE, rand_va(), ent);
  endtask

  // Drop valid and hold until every predicted word has come back
  task automatic wait_results_done();
    in_valid_i <= 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_walker_config(input logic [PA_MAX_W-1:0] root,
                                     input logic [PNONE_W-1:0] pnone);
    logic [CFG_DATA_W-1:0] w;
    wait_results_done();
    w = CFG_DATA_W'(rand64());
    w[PNONE_W-1:0] = pnone;
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_ROOT_TABLE_ADDR;
    cfg_wdata_i <= root;
    @(negedge clk_i);
    cfg_idx_i   <= CFG_PROT_NONE_BIT;
    cfg_wdata_i <= w;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    root_q      = root;
    pnone_pos   = pnone;
    n_settings++;
  endtask

  // Walk with given entries, stopping once the walk ends
  task automatic walk_with(input logic [VADDR_W-1:0] va, input logic [63:0] e4,
                           input logic [63:0] e3, input logic [63:0] e2,
                           input logic [63:0] e1);
    send_translate(va);
    send_entry(e4);
    if (tb_level != LVL_IDLE) send_entry(e3);
    if (tb_level != LVL_IDLE) send_entry(e2);
    if (tb_level != LVL_IDLE) send_entry(e1);
    n_walks++;
  endtask

  function automatic logic [63:0] make_entry(input walk_level_e lvl);
    logic [63:0] e;
    int          pick;
    e    = rand64();
    pick = $urandom_range(0, 99);
    if (lvl == LVL_1) begin
      if (pick < 30) begin
        e[pnone_pos]   = $urandom_range(0, 1);
        e[BIT_PRESENT] = 1'b0;
      end else begin
        e[BIT_PRESENT] = 1'b1;
      end
    end else begin
      e[BIT_PRESENT] = (pick >= 7);
      e[BIT_HUGE]    = (pick < 27);
    end
    return e;
  endfunction

  task automatic random_walk();
    send_translate(rand_va());
    while (tb_level != LVL_IDLE) begin
      if ($urandom_range(0, 99) < 8) send_translate(rand_va());
      send_entry(make_entry(tb_level));
    end
    n_walks++;
  endtask

  always @(negedge clk_i) begin
    if (hold_off > 0) begin
      out_ready_i <= 1'b0;
      hold_off--;
    end else if (out_stalls) begin
      out_ready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_words
    walk_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        report_error($sformatf("unexpected word, kind %0d", result_kind_o));
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (result_kind_o !== want.kind)
          report_error($sformatf("kind %0d, want %0d", result_kind_o, want.kind));
        if (read_addr_o !== want.read_addr)
          report_error($sformatf("read_addr %h, want %h", read_addr_o, want.read_addr));
        if (phys_addr_o !== want.phys_addr)
          report_error($sformatf("phys_addr %h, want %h", phys_addr_o, want.phys_addr));
        if (frame_size_o !== want.frame_size)
          report_error($sformatf("frame_size %0d, want %0d", frame_size_o,
                                 want.frame_size));
        if (fault_level_o !== want.fault_level)
          report_error($sformatf("fault_level %0d, want %0d", fault_level_o,
                                 want.fault_level));
        if (want.kind == KIND_DONE) n_done++;
        if (want.kind == KIND_DONE && want.frame_size != PAGE_4K) n_huge++;
        if (want.kind == KIND_FAULT) n_fault++;
      end
    end
  end

  // Reset values, extremes of the fields and every way a walk can end
  task automatic test_directed();
    send_entry('1);
    send_translate('0);
    send_translate('1);
    send_entry('1);
    send_entry(64'h0000_0000_0000_1001);
    send_entry(64'h000F_FFFF_FFFF_F001);
    send_entry(64'h000A_BCDE_F012_3200);
    n_walks++;
    walk_with('1, 64'hFFFF_FFFF_FFFF_FF7F, 64'hFFFF_FFFF_FFFF_FF7F,
              64'hFFFF_FFFF_FFFF_FF7F, 64'h0);
    walk_with(48'h8000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFE, '0, '0, '0);
    walk_with(rand_va(), 64'h1, 64'h0, '0, '0);
    walk_with(rand_va(), 64'h1, 64'h1, 64'h80, '0);
    walk_with('1, 64'h1, '1, '0, '0);
    walk_with(48'h7FFF_FFFF_FFFF, 64'h1, 64'h1, '1, '0);
    walk_with(rand_va(), 64'h1, 64'h1, 64'h1, '1);
  endtask

  task automatic test_config_extremes();
    write_walker_config('1, 6'd63);
    walk_with(rand_va(), 64'h1, 64'h1, 64'h1, 64'h8000_0000_0000_0000);
    walk_with(rand_va(), 64'h1, 64'h1, 64'h1, 64'h7FFF_FFFF_FFFF_FFFE);
    // prot-none on bit 0 coincides with present
    write_walker_config(52'h0_0000_0000_0FFF, 6'd0);
    walk_with('0, 64'h1, 64'h1, 64'h1, 64'hFFFF_FFFF_FFFF_FFFE);
    walk_with('1, 64'h1, 64'h1, 64'h1, 64'h1);
  endtask

  // Receiver holds off while the sender keeps offering words
  task automatic test_backpressure();
    wait_results_done();
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    hold_off   = HOLD_OFF_CYCLES;
    repeat (8) random_walk();
    wait_results_done();
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
  endtask

  task automatic test_random_walks(input int n_words);
    int goal;
    goal = n_result_words + n_words;
    while (n_result_words < goal) begin
      if ($urandom_range(0, 99) < 8) send_entry(rand64());
      if ($urandom_range(0, 59) == 0) wait_results_done();
      random_walk();
    end
  endtask

  task automatic test_random_phases();
    logic [63:0] r;
    for (int p = 0; p < 6; p++) begin
      r = rand64();
      case (p)
        0: write_walker_config('1, 6'd63);
        1: write_walker_config('0, 6'd0);
        2: write_walker_config(r[PA_MAX_W-1:0], PNONE_RESET);
        default: write_walker_config(r[PA_MAX_W-1:0], PNONE_W'($urandom_range(0, 63)));
      endcase
      // one phase runs flat out on both sides
      in_gaps    = (p != 3);
      out_stalls = (p != 3);
      test_random_walks(250);
    end
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_ROOT_TABLE_ADDR;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    req_type_i   = REQ_TRANSLATE;
    virt_addr_i  = '0;
    entry_data_i = '0;
    out_ready_i  = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_directed();
    test_config_extremes();
    test_backpressure();
    test_random_phases();

    wait_results_done();
    repeat (10) @(posedge clk_i);
    if (pending_outcomes.size() != 0)
      report_error($sformatf("%0d words never came", pending_outcomes.size()));
    $display("Checked %0d words over %0d walks: %0d translations (%0d huge), %0d faults",
             n_checked, n_walks, n_done, n_huge, n_fault);
    $display("%0d ignored words, %0d register settings, stalls and a %0d-cycle hold-off",
             n_ignored, n_settings, HOLD_OFF_CYCLES);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
